[rtl/mclp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mclp_pkg: shared types and constants
// Item layouts, register indexes and reset values for the multi-click /
// long-press detector.
// ---------------------------------------------------------------------------
package mclp_pkg;

  localparam int CHANNEL_W  = 7;
  localparam int TIME_W     = 32;
  localparam int CFG_W      = 16;
  localparam int PCOUNT_W   = 8;

  // Register indexes on the configuration port
  localparam logic REG_DOUBLE_CLICK = 1'b0;
  localparam logic REG_HOLD         = 1'b1;

  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = 16'd250;
  localparam logic [CFG_W-1:0] HOLD_RESET         = 16'd500;

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic                 level;
    logic [TIME_W-1:0]    now_ms;
  } in_item_t;

  typedef struct packed {
    logic                is_pressed;
    logic                press_edge;
    logic                release_edge;
    logic [PCOUNT_W-1:0] press_count;
    logic                held_long_now;
    logic                release_after_long;
  } out_item_t;

endpackage

[rtl/mclp_state_mem.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mclp_state_mem: per-channel state memory
// One word per channel, registered read, one write port, a clearing sweep
// after reset and a forward path for a write to the address read at the
// same edge.
// ---------------------------------------------------------------------------
module mclp_state_mem #(
  parameter int DEPTH  = 128,
  parameter int IDX_W  = 7,
  parameter int WORD_W = 42
) (
  input  logic              clk,
  input  logic              rst,
  output logic              busy,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [WORD_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] ram_q;
  logic [WORD_W-1:0] byp_data;
  logic              byp_hit;
  logic [IDX_W-1:0]  clr_idx;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_addr;
  logic [WORD_W-1:0] mem_wdata;

  // Sweep zeros through every entry after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      if (clr_idx == IDX_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  always_comb begin
    mem_we    = busy | wr_en;
    mem_addr  = busy ? clr_idx : wr_idx;
    mem_wdata = busy ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      ram_q <= mem[rd_idx];
    end
  end

  // Forward a write that lands on the same edge as the read
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else if (rd_en) begin
      byp_hit <= wr_en && (wr_idx == rd_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp_hit ? byp_data : ram_q;

endmodule

[rtl/mclp_update.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mclp_update: per-sample channel update
// Edge detection, window and hold checks, count update and result flags.
// ---------------------------------------------------------------------------
module mclp_update
  import mclp_pkg::*;
#(
  parameter int COUNT_BITS = 8
) (
  input  logic                  in_range,
  input  logic                  level,
  input  logic [TIME_W-1:0]     now_ms,
  input  logic [CFG_W-1:0]      double_click_ms,
  input  logic [CFG_W-1:0]      hold_ms,
  input  logic                  cur_pressed,
  input  logic                  cur_known,
  input  logic [COUNT_BITS-1:0] cur_count,
  input  logic [TIME_W-1:0]     cur_stamp,
  output logic                  nxt_pressed,
  output logic                  nxt_known,
  output logic [COUNT_BITS-1:0] nxt_count,
  output logic [TIME_W-1:0]     nxt_stamp,
  output out_item_t             result
);

  localparam int PC_W = COUNT_BITS + PCOUNT_W;

  logic [TIME_W-1:0]     elapsed;
  logic                  in_window;
  logic                  within_hold;
  logic [COUNT_BITS-1:0] count_inc;
  logic [PC_W-1:0]       pc_wide;

  // Stamp holds the press time while pressed, the release time otherwise
  assign elapsed     = now_ms - cur_stamp;
  assign in_window   = elapsed <= TIME_W'(double_click_ms);
  assign within_hold = elapsed <= TIME_W'(hold_ms);
  assign count_inc   = (&cur_count) ? cur_count : cur_count + 1'b1;

  always_comb begin
    nxt_pressed = cur_pressed;
    nxt_known   = cur_known;
    nxt_count   = cur_count;
    nxt_stamp   = cur_stamp;
    result      = '0;

    if (level && !cur_pressed) begin
      nxt_count         = (cur_known && in_window) ? count_inc : '0;
      nxt_stamp         = now_ms;
      nxt_pressed       = 1'b1;
      result.press_edge = 1'b1;
    end else if (!level && cur_pressed) begin
      nxt_count                 = ((cur_count != '0) && within_hold) ? count_inc : '0;
      nxt_stamp                 = now_ms;
      nxt_known                 = 1'b1;
      nxt_pressed               = 1'b0;
      result.release_edge       = 1'b1;
      result.release_after_long = !within_hold;
    end else if (!level && (cur_count != '0)) begin
      if (!cur_known || !in_window) begin
        nxt_count = '0;
      end
    end else if (level) begin
      result.held_long_now = !within_hold;
    end

    pc_wide            = PC_W'(nxt_count >> 1) + PC_W'(1);
    result.is_pressed  = nxt_pressed;
    result.press_count = pc_wide[PCOUNT_W-1:0];

    // Out-of-range channel: empty result, count field reads one
    if (!in_range) begin
      result             = '0;
      result.press_count = PCOUNT_W'(1);
    end
  end

endmodule

[rtl/multi_click_long_press_detector.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_click_long_press_detector: click, multi-click and long-press events
// Tracks press/release history per channel and reports edges, the repeated
// press count and long-hold flags for every sample.
// ---------------------------------------------------------------------------
// Each input item is one sampled level of one channel with a millisecond
// timestamp; each item yields exactly one result item for that channel.
// The block accepts one item per clock while the output side is not
// stalled; each item passes through the registered read of the
// per-channel state memory, then the update and the result register.
// Back-to-back samples of the same channel are safe; the state written
// by one item is forwarded to the next. After reset the block sweeps
// the state memory clear, one channel per cycle, and holds in_ready low
// until the sweep is done; configuration writes are taken at any time
// but should only be issued while no item is in flight. Channels at or
// above CHANNELS leave state untouched and report no events.
// ---------------------------------------------------------------------------
module multi_click_long_press_detector
  import mclp_pkg::*;
#(
  parameter int CHANNELS   = 128,
  parameter int COUNT_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int IDX_W  = $clog2(CHANNELS);
  // Word layout: pressed, release seen, count, time stamp
  localparam int WORD_W = 2 + COUNT_BITS + TIME_W;

  logic [CFG_W-1:0] double_click_ms;
  logic [CFG_W-1:0] hold_ms;

  logic             mem_busy;
  logic             in_fire;
  logic             s1_adv;
  logic             s1_fire;
  logic             s1_valid;
  in_item_t         s1_item;
  logic             s1_in_range;
  logic [IDX_W-1:0] s1_idx;
  logic [IDX_W-1:0] in_idx;

  logic [WORD_W-1:0]     cur_word;
  logic [WORD_W-1:0]     nxt_word;
  logic                  nxt_pressed;
  logic                  nxt_known;
  logic [COUNT_BITS-1:0] nxt_count;
  logic [TIME_W-1:0]     nxt_stamp;
  out_item_t             result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      double_click_ms <= DOUBLE_CLICK_RESET;
      hold_ms         <= HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOUBLE_CLICK: double_click_ms <= cfg_wdata;
        REG_HOLD:         hold_ms         <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // Handshake: stage 1 moves on whenever the result register is free
  assign s1_adv   = !out_valid || out_ready;
  assign s1_fire  = s1_valid && s1_adv;
  assign in_ready = !mem_busy && (!s1_valid || s1_adv);
  assign in_fire  = in_valid && in_ready;
  assign in_idx   = IDX_W'(in_item.channel);

  // Stage 1: hold the item while its state word is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || s1_adv) begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item     <= in_item;
      s1_idx      <= in_idx;
      s1_in_range <= 32'(in_item.channel) < CHANNELS;
    end
  end

  mclp_state_mem #(
    .DEPTH  (CHANNELS),
    .IDX_W  (IDX_W),
    .WORD_W (WORD_W)
  ) u_state (
    .clk     (clk),
    .rst     (rst),
    .busy    (mem_busy),
    .rd_en   (in_fire),
    .rd_idx  (in_idx),
    .rd_data (cur_word),
    .wr_en   (s1_fire && s1_in_range),
    .wr_idx  (s1_idx),
    .wr_data (nxt_word)
  );

  mclp_update #(
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .in_range        (s1_in_range),
    .level           (s1_item.level),
    .now_ms          (s1_item.now_ms),
    .double_click_ms (double_click_ms),
    .hold_ms         (hold_ms),
    .cur_pressed     (cur_word[WORD_W-1]),
    .cur_known       (cur_word[WORD_W-2]),
    .cur_count       (cur_word[WORD_W-3:TIME_W]),
    .cur_stamp       (cur_word[TIME_W-1:0]),
    .nxt_pressed     (nxt_pressed),
    .nxt_known       (nxt_known),
    .nxt_count       (nxt_count),
    .nxt_stamp       (nxt_stamp),
    .result          (result)
  );

  assign nxt_word = {nxt_pressed, nxt_known, nxt_count, nxt_stamp};

  // Result register: advance when taken or empty
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item <= result;
    end
  end

endmodule

[rtl/mclp_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mclp_checker: port-level checks
// Watches the detector's ports for handshake and result consistency.
// ---------------------------------------------------------------------------
module mclp_checker
  import mclp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // Clearing sweep blocks input right after reset
  a_ready_low_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("in_ready high during state clearing");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("waiting input item changed or dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  a_edge_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.press_edge && !out_item.is_pressed) &&
                  !(out_item.release_edge && out_item.is_pressed))
    else $error("edge flag disagrees with pressed state");

  a_long_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.held_long_now &&
                    (!out_item.is_pressed || out_item.press_edge)) &&
                  !(out_item.release_after_long && !out_item.release_edge))
    else $error("long-hold flag without matching press state");

endmodule

bind multi_click_long_press_detector mclp_checker u_mclp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
